@@ rtl/shm_pkg.sv @@
// shared constants and types for the sliding hour/minute counter
package shm_pkg;

    localparam int BUCKET_COUNT_DEF       = 60;
    localparam int SECONDS_PER_BUCKET_DEF = 60;

    localparam int TIME_W    = 32;
    localparam int AMT_W     = 32;
    localparam int CNT_W     = 64;
    localparam int MIN_OUT_W = 27;
    localparam int IDX_IN_W  = 6;
    localparam int STAT_W    = 2;

    localparam logic [STAT_W-1:0] ST_COUNTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_OLD = 2'd1;
    localparam logic [STAT_W-1:0] ST_READ    = 2'd2;

    localparam logic CMD_INC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              go;
        logic [TIME_W-1:0] dividend;
    } t_div_req;

endpackage

@@ rtl/shm_ram.sv @@
// generic single-write, single-read ram with registered read data
module shm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/shm_div.sv @@
// constant divider by reciprocal multiplication, one of two fixed divisors per request
module shm_div #(
    parameter int DIV_W     = 12,
    parameter int DIVISOR_A = 60,
    parameter int DIVISOR_B = 60
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  shm_pkg::t_div_req          i_req,
    input  logic                       i_sel_b,
    output logic                       o_done,
    output logic [shm_pkg::TIME_W-1:0] o_quotient,
    output logic [DIV_W-1:0]           o_remainder
);

    import shm_pkg::*;

    // x / d == (x * ceil(2^(TIME_W+l) / d)) >> (TIME_W+l) for every x below 2^TIME_W,
    // with 2^l >= d; the reciprocal fits in TIME_W+1 bits
    localparam int SHIFT_A = TIME_W + $clog2(DIVISOR_A);
    localparam int SHIFT_B = TIME_W + $clog2(DIVISOR_B);
    localparam logic [63:0] RECIP_A_FULL =
        ((64'd1 << SHIFT_A) + 64'(DIVISOR_A) - 64'd1) / 64'(DIVISOR_A);
    localparam logic [63:0] RECIP_B_FULL =
        ((64'd1 << SHIFT_B) + 64'(DIVISOR_B) - 64'd1) / 64'(DIVISOR_B);
    localparam logic [TIME_W:0] RECIP_A = (TIME_W + 1)'(RECIP_A_FULL);
    localparam logic [TIME_W:0] RECIP_B = (TIME_W + 1)'(RECIP_B_FULL);
    localparam logic [DIV_W-1:0] DIV_A = DIV_W'(DIVISOR_A);
    localparam logic [DIV_W-1:0] DIV_B = DIV_W'(DIVISOR_B);
    localparam int PROD_W = 2 * TIME_W + 1;

    logic                r_busy;
    logic                r_done;
    logic                r_sel;
    logic [TIME_W-1:0]   r_x;
    logic [PROD_W-1:0]   r_prod;
    logic [TIME_W-1:0]   r_quo;

    logic [TIME_W:0]     recip;
    logic [PROD_W-1:0]   prod;
    logic [DIV_W-1:0]    divisor;

    assign recip   = i_sel_b ? RECIP_B : RECIP_A;
    assign prod    = PROD_W'(i_req.dividend) * PROD_W'(recip);
    assign divisor = r_sel ? DIV_B : DIV_A;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_req.go;
            r_done <= r_busy;
        end
        if (i_req.go) begin
            r_x    <= i_req.dividend;
            r_sel  <= i_sel_b;
            r_prod <= prod;
        end
        if (r_busy) begin
            r_quo <= r_sel ? TIME_W'(r_prod >> SHIFT_B) : TIME_W'(r_prod >> SHIFT_A);
        end
    end

    // remainder is below the divisor, so the low bits of x - q * d are enough
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_x[DIV_W-1:0] - DIV_W'(r_quo[DIV_W-1:0] * divisor);

endmodule

@@ rtl/sliding_hour_minute_counter.sv @@
// Sliding window counter: BUCKET_COUNT per-minute buckets in one ram plus an all-time total.
// Times become minutes and bucket slots in a shared constant divider (reciprocal multiply).
// An increment runs its two divisions and then a deciding step; the result of a sample
// that is too old is registered from the deciding step, a sample in a minute already open
// goes through a read-modify-write of its bucket, and for a sample in a newer minute the n
// skipped buckets are zeroed one per cycle (n at most BUCKET_COUNT) before its bucket is
// written. A read brings an out-of-range index into range by subtracting BUCKET_COUNT,
// then reads the ram and registers its result. After reset and after each origin time
// write the block runs a clearing pass over all BUCKET_COUNT buckets and two divisions,
// during which nothing is accepted; configuration is taken only while the block is idle.
// One item is in work at a time; a finished result waits in the output register while
// the next item is accepted, and a result that is still waiting there holds the following
// one back for as long as the receiver stalls.
module sliding_hour_minute_counter #(
    parameter int BUCKET_COUNT       = shm_pkg::BUCKET_COUNT_DEF,
    parameter int SECONDS_PER_BUCKET = shm_pkg::SECONDS_PER_BUCKET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [shm_pkg::TIME_W-1:0]    i_cfg_origin_time,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [shm_pkg::TIME_W-1:0]    i_event_time,
    input  logic [shm_pkg::AMT_W-1:0]     i_amount,
    input  logic [shm_pkg::IDX_IN_W-1:0]  i_bucket_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [shm_pkg::STAT_W-1:0]    o_status,
    output logic [shm_pkg::CNT_W-1:0]     o_bucket_count,
    output logic [shm_pkg::MIN_OUT_W-1:0] o_bucket_minute,
    output logic [shm_pkg::CNT_W-1:0]     o_total_count,
    output logic [shm_pkg::TIME_W-1:0]    o_latest_seconds
);

    import shm_pkg::*;

    localparam int IW    = $clog2(BUCKET_COUNT);
    localparam int NB_W  = $clog2(BUCKET_COUNT + 1);
    localparam int SPB_W = $clog2(SECONDS_PER_BUCKET + 1);
    localparam int DIV_W = (NB_W > SPB_W) ? NB_W : SPB_W;
    localparam int CMPW  = (NB_W > IDX_IN_W) ? NB_W : IDX_IN_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(BUCKET_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_CFG_LMIN,
        S_CFG_LIDX,
        S_IDLE,
        S_RD_REDUCE,
        S_RD_DATA,
        S_INC_MIN,
        S_INC_SLOT,
        S_INC_DECIDE,
        S_INC_ZERO,
        S_INC_NEW,
        S_INC_RMW
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0]       r_ptr, n_ptr;
    logic [NB_W-1:0]     r_cnt, n_cnt;
    logic [TIME_W-1:0]   r_ev, n_ev;
    logic [AMT_W-1:0]    r_amt, n_amt;
    logic [IDX_IN_W-1:0] r_idx, n_idx;
    logic [TIME_W-1:0]   r_smin, n_smin;
    logic [IW-1:0]       r_slot, n_slot;
    logic [TIME_W-1:0]   r_lmin, n_lmin;
    logic [IW-1:0]       r_lidx, n_lidx;
    logic [TIME_W-1:0]   r_newest, n_newest;
    logic [CNT_W-1:0]    r_total, n_total;
    t_div_req            r_div_req, n_div_req;
    logic                r_div_by_nb, n_div_by_nb;
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [CNT_W-1:0]    r_bcount, n_bcount;
    logic [MIN_OUT_W-1:0] r_bmin, n_bmin;
    logic [CNT_W-1:0]    r_tot_out, n_tot_out;
    logic [TIME_W-1:0]   r_lat_out, n_lat_out;

    // ram ports
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    // divider ports
    logic              div_done;
    logic [TIME_W-1:0] div_quo;
    logic [DIV_W-1:0]  div_rem;

    // datapath helpers
    logic              out_free;
    logic              too_old;
    logic              advance;
    logic [TIME_W-1:0] gap;
    logic [NB_W-1:0]   gap_cap;
    logic [IW-1:0]     lidx_next;
    logic [IW-1:0]     rd_idx;
    logic [NB_W:0]     back_sum;
    logic [NB_W:0]     back;
    logic [TIME_W-1:0] back_ext;
    logic [TIME_W-1:0] rd_minute;
    logic [CNT_W-1:0]  total_inc;
    logic [CNT_W-1:0]  bucket_sum;

    shm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BUCKET_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    shm_div #(
        .DIV_W     (DIV_W),
        .DIVISOR_A (SECONDS_PER_BUCKET),
        .DIVISOR_B (BUCKET_COUNT)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (r_div_req),
        .i_sel_b     (r_div_by_nb),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign out_free  = !r_out_valid || i_out_ready;
    assign too_old   = ({1'b0, r_smin} + (TIME_W + 1)'(BUCKET_COUNT)) <= {1'b0, r_lmin};
    assign advance   = r_ev > r_newest;
    assign gap       = r_smin - r_lmin;
    assign gap_cap   = (gap > TIME_W'(BUCKET_COUNT)) ? NB_W'(BUCKET_COUNT) : NB_W'(gap);
    assign lidx_next = (r_lidx == LAST_IDX) ? '0 : IW'(r_lidx + 1'b1);
    assign total_inc = r_total + CNT_W'(r_amt);
    assign bucket_sum = ram_rdata + CNT_W'(r_amt);

    // minute that a read bucket stands for: steps back from the newest minute
    assign rd_idx    = IW'(r_idx);
    assign back_sum  = (NB_W + 1)'(BUCKET_COUNT) + (NB_W + 1)'(r_lidx) - (NB_W + 1)'(rd_idx);
    assign back      = (back_sum >= (NB_W + 1)'(BUCKET_COUNT)) ?
                       (NB_W + 1)'(back_sum - (NB_W + 1)'(BUCKET_COUNT)) : back_sum;
    assign back_ext  = TIME_W'(back);
    assign rd_minute = (back_ext > r_lmin) ? '0 : r_lmin - back_ext;

    // a pending configuration write takes precedence over an input transaction
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_ev        = r_ev;
        n_amt       = r_amt;
        n_idx       = r_idx;
        n_smin      = r_smin;
        n_slot      = r_slot;
        n_lmin      = r_lmin;
        n_lidx      = r_lidx;
        n_newest    = r_newest;
        n_total     = r_total;
        n_div_req   = '{go: 1'b0, dividend: r_div_req.dividend};
        n_div_by_nb = r_div_by_nb;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_bcount    = r_bcount;
        n_bmin      = r_bmin;
        n_tot_out   = r_tot_out;
        n_lat_out   = r_lat_out;
        ram_we      = 1'b0;
        ram_waddr   = r_ptr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_slot;

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_ptr  = IW'(r_ptr + 1'b1);
                if (r_ptr == LAST_IDX) begin
                    n_div_req   = '{go: 1'b1, dividend: r_newest};
                    n_div_by_nb = 1'b0;
                    n_state     = S_CFG_LMIN;
                end
            end
            S_CFG_LMIN: begin
                if (div_done) begin
                    n_lmin      = div_quo;
                    n_div_req   = '{go: 1'b1, dividend: div_quo};
                    n_div_by_nb = 1'b1;
                    n_state     = S_CFG_LIDX;
                end
            end
            S_CFG_LIDX: begin
                if (div_done) begin
                    n_lidx  = div_rem[IW-1:0];
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_newest = i_cfg_origin_time;
                    n_total  = '0;
                    n_ptr    = '0;
                    n_state  = S_CLEAR;
                end else if (i_in_valid) begin
                    n_ev  = i_event_time;
                    n_amt = i_amount;
                    n_idx = i_bucket_index;
                    if (i_cmd == CMD_READ) begin
                        n_state = S_RD_REDUCE;
                    end else begin
                        n_div_req   = '{go: 1'b1, dividend: i_event_time};
                        n_div_by_nb = 1'b0;
                        n_state     = S_INC_MIN;
                    end
                end
            end
            S_RD_REDUCE: begin
                if (CMPW'(r_idx) >= CMPW'(BUCKET_COUNT)) begin
                    n_idx = IDX_IN_W'(CMPW'(r_idx) - CMPW'(BUCKET_COUNT));
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = rd_idx;
                    n_state   = S_RD_DATA;
                end
            end
            S_RD_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_READ;
                    n_bcount    = ram_rdata;
                    n_bmin      = rd_minute[MIN_OUT_W-1:0];
                    n_tot_out   = r_total;
                    n_lat_out   = r_newest;
                    n_state     = S_IDLE;
                end
            end
            S_INC_MIN: begin
                if (div_done) begin
                    n_smin      = div_quo;
                    n_div_req   = '{go: 1'b1, dividend: div_quo};
                    n_div_by_nb = 1'b1;
                    n_state     = S_INC_SLOT;
                end
            end
            S_INC_SLOT: begin
                if (div_done) begin
                    n_slot  = div_rem[IW-1:0];
                    n_state = S_INC_DECIDE;
                end
            end
            S_INC_DECIDE: begin
                if (too_old) begin
                    if (out_free) begin
                        n_total     = total_inc;
                        n_out_valid = 1'b1;
                        n_status    = ST_TOO_OLD;
                        n_bcount    = '0;
                        n_bmin      = '0;
                        n_tot_out   = total_inc;
                        n_lat_out   = r_newest;
                        n_state     = S_IDLE;
                    end
                end else if (advance && gap != '0) begin
                    // newer minute: zero the skipped buckets, the new slot among them
                    n_newest = r_ev;
                    n_lmin   = r_smin;
                    n_lidx   = r_slot;
                    n_ptr    = lidx_next;
                    n_cnt    = gap_cap;
                    n_state  = S_INC_ZERO;
                end else begin
                    if (advance) begin
                        n_newest = r_ev;
                    end
                    ram_re    = 1'b1;
                    ram_raddr = r_slot;
                    n_state   = S_INC_RMW;
                end
            end
            S_INC_ZERO: begin
                ram_we = 1'b1;
                n_ptr  = (r_ptr == LAST_IDX) ? '0 : IW'(r_ptr + 1'b1);
                n_cnt  = NB_W'(r_cnt - 1'b1);
                if (r_cnt == NB_W'(1)) begin
                    n_state = S_INC_NEW;
                end
            end
            S_INC_NEW: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_slot;
                    ram_wdata   = CNT_W'(r_amt);
                    n_total     = total_inc;
                    n_out_valid = 1'b1;
                    n_status    = ST_COUNTED;
                    n_bcount    = CNT_W'(r_amt);
                    n_bmin      = r_smin[MIN_OUT_W-1:0];
                    n_tot_out   = total_inc;
                    n_lat_out   = r_newest;
                    n_state     = S_IDLE;
                end
            end
            S_INC_RMW: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_slot;
                    ram_wdata   = bucket_sum;
                    n_total     = total_inc;
                    n_out_valid = 1'b1;
                    n_status    = ST_COUNTED;
                    n_bcount    = bucket_sum;
                    n_bmin      = r_smin[MIN_OUT_W-1:0];
                    n_tot_out   = total_inc;
                    n_lat_out   = r_newest;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_newest    <= '0;
            r_total     <= '0;
            r_div_req   <= '0;
            r_div_by_nb <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_newest    <= n_newest;
            r_total     <= n_total;
            r_div_req   <= n_div_req;
            r_div_by_nb <= n_div_by_nb;
            r_out_valid <= n_out_valid;
        end
        r_cnt     <= n_cnt;
        r_ev      <= n_ev;
        r_amt     <= n_amt;
        r_idx     <= n_idx;
        r_smin    <= n_smin;
        r_slot    <= n_slot;
        r_lmin    <= n_lmin;
        r_lidx    <= n_lidx;
        r_status  <= n_status;
        r_bcount  <= n_bcount;
        r_bmin    <= n_bmin;
        r_tot_out <= n_tot_out;
        r_lat_out <= n_lat_out;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_bucket_count   = r_bcount;
    assign o_bucket_minute  = r_bmin;
    assign o_total_count    = r_tot_out;
    assign o_latest_seconds = r_lat_out;

endmodule

@@ rtl/shm_checker.sv @@
// port-level checks for the sliding hour/minute counter, bound to the top level
module shm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [shm_pkg::STAT_W-1:0]    o_status,
    input logic [shm_pkg::CNT_W-1:0]     o_bucket_count,
    input logic [shm_pkg::MIN_OUT_W-1:0] o_bucket_minute,
    input logic [shm_pkg::CNT_W-1:0]     o_total_count,
    input logic [shm_pkg::TIME_W-1:0]    o_latest_seconds
);

    import shm_pkg::*;

    // a waiting result keeps its valid and its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_total_count)
            && $stable(o_bucket_count) && $stable(o_status)
            && $stable(o_bucket_minute) && $stable(o_latest_seconds))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_COUNTED || o_status == ST_TOO_OLD
            || o_status == ST_READ))
        else $error("undefined status code");

    // a sample outside the window never reports a bucket
    a_too_old_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_TOO_OLD |-> o_bucket_count == '0
            && o_bucket_minute == '0)
        else $error("too-old result carries bucket data");

    // an origin time write starts the clearing pass
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_in_ready && !o_cfg_ready)
        else $error("block ready right after a configuration write");

    // one transaction in work at a time
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && !o_cfg_ready)
        else $error("block ready right after accepting a transaction");

endmodule

bind sliding_hour_minute_counter shm_checker u_shm_checker (.*);
